[design/turn_signal_controller_assert.svh]
// ----------------------------------------------------------------------------
// Turn signal controller assertion macros
// Concurrent assertion wrappers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef TURN_SIGNAL_CONTROLLER_ASSERT_SVH
`define TURN_SIGNAL_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("turn signal controller assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("turn signal controller assertion failed");

`endif

[design/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// Turn signal controller package
// Types, codes and the running-light pattern shared by the design files.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int PATTERN_LENGTH = 6;
   localparam int PATTERN_INDEX_WIDTH = $clog2(PATTERN_LENGTH);

   localparam logic [9:0] PRESS_TIMER_MAX = 10'd1023;
   localparam logic [7:0] BLINK_TIMER_MAX = 8'd255;

   localparam logic [7:0] BLINK_STEP_RESET = 8'd10;
   localparam logic [9:0] LONG_PRESS_RESET = 10'd60;
   localparam logic [3:0] COMFORT_RESET = 4'd4;

   localparam logic signed [4:0] PASSES_ENDLESS = -5'sd1;
   localparam logic signed [4:0] PASSES_ONE = 5'sd1;
   localparam logic signed [4:0] PASSES_NONE = 5'sd0;

   localparam logic [2:0] LAMP_OFF = 3'b000;
   localparam logic [2:0] LAMP_RED = 3'b001;
   localparam logic [2:0] LAMP_ORANGE = 3'b010;
   localparam logic [2:0] LAMP_GREEN = 3'b100;

   localparam logic [1:0] BLINK_MODE_STOPPED = 2'd0;
   localparam logic [1:0] BLINK_MODE_LEFT = 2'd1;
   localparam logic [1:0] BLINK_MODE_RIGHT = 2'd2;

   localparam logic [1:0] CSR_BLINK_STEP_POLLS = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS_POLLS = 2'd1;
   localparam logic [1:0] CSR_COMFORT_CYCLES = 2'd2;

   typedef enum logic [2:0] {
      MODE_STOP  = 3'b001,
      MODE_LEFT  = 3'b010,
      MODE_RIGHT = 3'b100
   } mode_type;

   typedef enum logic [4:0] {
      CLS_NONE   = 5'b00001,
      CLS_LSHORT = 5'b00010,
      CLS_LLONG  = 5'b00100,
      CLS_RSHORT = 5'b01000,
      CLS_RLONG  = 5'b10000
   } press_class_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_LPRESS,
      EV_LREL,
      EV_LLONG,
      EV_RPRESS,
      EV_RREL,
      EV_RLONG
   } button_event_type;

   typedef struct packed {
      mode_type                       mode;
      logic [PATTERN_INDEX_WIDTH-1:0] pattern_index;
      logic signed [4:0]              passes_left;
      press_class_type                press_class;
      logic                           left_held;
      logic                           right_held;
      logic [9:0]                     press_timer;
      logic                           press_timer_running;
      logic [7:0]                     blink_timer;
      logic [2:0]                     left_out;
      logic [2:0]                     right_out;
   } state_type;

   function automatic logic [2:0] pattern_at(input logic [PATTERN_INDEX_WIDTH-1:0] index);
      logic [4:0] wide;
      logic [2:0] lamps;
      wide = 5'(index);
      lamps = LAMP_OFF;
      if (wide == 5'd0) begin
         lamps = LAMP_RED;
      end else if (wide == 5'd1) begin
         lamps = LAMP_ORANGE;
      end else if (wide == 5'd2) begin
         lamps = LAMP_GREEN;
      end
      return lamps;
   endfunction

   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      unique case (mode)
         MODE_LEFT: begin
            code = BLINK_MODE_LEFT;
         end
         MODE_RIGHT: begin
            code = BLINK_MODE_RIGHT;
         end
         default: begin
            code = BLINK_MODE_STOPPED;
         end
      endcase
      return code;
   endfunction

endpackage

[design/tsc_event_unit.sv]
// ----------------------------------------------------------------------------
// Turn signal controller button event unit
// Advances the press timer, detects one button event per poll with left over
// right priority and applies it to the blink mode, pass count and press class.
// ----------------------------------------------------------------------------
module tsc_event_unit (
   input  tsc_pkg::state_type state_in,
   input  logic               left_button,
   input  logic               right_button,
   input  logic [9:0]         long_press_polls,
   input  logic [3:0]         comfort_cycles,
   output tsc_pkg::state_type state_out
);

   tsc_pkg::button_event_type ev;

   always_comb begin
      state_out = state_in;
      ev = tsc_pkg::EV_NONE;

      if (state_out.press_timer_running && (state_out.press_timer != tsc_pkg::PRESS_TIMER_MAX)) begin
         state_out.press_timer = state_out.press_timer + 10'd1;
      end

      priority if (left_button && !state_out.left_held) begin
         ev = tsc_pkg::EV_LPRESS;
         state_out.left_held = 1'b1;
         state_out.press_timer = 10'd0;
         state_out.press_timer_running = 1'b1;
      end else if (!left_button && state_out.left_held) begin
         ev = tsc_pkg::EV_LREL;
         state_out.left_held = 1'b0;
         state_out.press_timer_running = 1'b0;
      end else if (state_out.left_held && (state_out.press_timer >= long_press_polls)) begin
         ev = tsc_pkg::EV_LLONG;
      end else if (right_button && !state_out.right_held) begin
         ev = tsc_pkg::EV_RPRESS;
         state_out.right_held = 1'b1;
         state_out.press_timer = 10'd0;
         state_out.press_timer_running = 1'b1;
      end else if (!right_button && state_out.right_held) begin
         ev = tsc_pkg::EV_RREL;
         state_out.right_held = 1'b0;
         state_out.press_timer_running = 1'b0;
      end else if (state_out.right_held && (state_out.press_timer >= long_press_polls)) begin
         ev = tsc_pkg::EV_RLONG;
      end else begin
         ev = tsc_pkg::EV_NONE;
      end

      unique case (ev)
         tsc_pkg::EV_LPRESS: begin
            if (state_out.press_class == tsc_pkg::CLS_RSHORT) begin
               state_out.mode = tsc_pkg::MODE_STOP;
               state_out.press_class = tsc_pkg::CLS_NONE;
            end else begin
               state_out.mode = tsc_pkg::MODE_LEFT;
               state_out.passes_left = $signed({1'b0, comfort_cycles});
               state_out.press_class = tsc_pkg::CLS_LSHORT;
            end
         end
         tsc_pkg::EV_LREL: begin
            if (state_out.press_class == tsc_pkg::CLS_LLONG) begin
               state_out.passes_left = tsc_pkg::PASSES_ONE;
            end
         end
         tsc_pkg::EV_LLONG: begin
            state_out.press_class = tsc_pkg::CLS_LLONG;
            state_out.mode = tsc_pkg::MODE_LEFT;
            state_out.passes_left = tsc_pkg::PASSES_ENDLESS;
         end
         tsc_pkg::EV_RPRESS: begin
            if (state_out.press_class == tsc_pkg::CLS_LSHORT) begin
               state_out.mode = tsc_pkg::MODE_STOP;
               state_out.press_class = tsc_pkg::CLS_NONE;
            end else begin
               state_out.mode = tsc_pkg::MODE_RIGHT;
               state_out.passes_left = $signed({1'b0, comfort_cycles});
               state_out.press_class = tsc_pkg::CLS_RSHORT;
            end
         end
         tsc_pkg::EV_RREL: begin
            if (state_out.press_class == tsc_pkg::CLS_RLONG) begin
               state_out.passes_left = tsc_pkg::PASSES_ONE;
            end
         end
         tsc_pkg::EV_RLONG: begin
            state_out.press_class = tsc_pkg::CLS_RLONG;
            state_out.mode = tsc_pkg::MODE_RIGHT;
            state_out.passes_left = tsc_pkg::PASSES_ENDLESS;
         end
         default: begin
         end
      endcase

      if (state_out.mode == tsc_pkg::MODE_STOP) begin
         state_out.press_class = tsc_pkg::CLS_NONE;
      end
   end

endmodule

[design/tsc_blink_unit.sv]
// ----------------------------------------------------------------------------
// Turn signal controller blink unit
// Advances the blink timer and steps the running-light pattern on the active
// side, counting finished passes and stopping when they run out.
// ----------------------------------------------------------------------------
module tsc_blink_unit (
   input  tsc_pkg::state_type state_in,
   input  logic [7:0]         blink_step_polls,
   output tsc_pkg::state_type state_out
);

   logic [tsc_pkg::PATTERN_INDEX_WIDTH:0] index_next;
   logic [2:0]                            lamps;

   always_comb begin
      state_out = state_in;
      index_next = {1'b0, state_in.pattern_index} + (tsc_pkg::PATTERN_INDEX_WIDTH + 1)'(1);
      lamps = tsc_pkg::pattern_at(state_in.pattern_index);

      if (state_out.blink_timer != tsc_pkg::BLINK_TIMER_MAX) begin
         state_out.blink_timer = state_out.blink_timer + 8'd1;
      end

      if (state_out.blink_timer >= blink_step_polls) begin
         state_out.blink_timer = 8'd0;
         if (state_out.mode == tsc_pkg::MODE_STOP) begin
            state_out.left_out = tsc_pkg::LAMP_OFF;
            state_out.right_out = tsc_pkg::LAMP_OFF;
            state_out.pattern_index = '0;
         end else begin
            if (state_out.mode == tsc_pkg::MODE_LEFT) begin
               state_out.left_out = lamps;
               state_out.right_out = tsc_pkg::LAMP_OFF;
            end else begin
               state_out.left_out = tsc_pkg::LAMP_OFF;
               state_out.right_out = lamps;
            end
            if (index_next >= (tsc_pkg::PATTERN_INDEX_WIDTH + 1)'(tsc_pkg::PATTERN_LENGTH)) begin
               state_out.pattern_index = '0;
               state_out.passes_left = state_out.passes_left - 5'sd1;
            end else begin
               state_out.pattern_index = index_next[tsc_pkg::PATTERN_INDEX_WIDTH-1:0];
            end
         end
         if (state_out.passes_left == tsc_pkg::PASSES_NONE) begin
            state_out.mode = tsc_pkg::MODE_STOP;
         end else if (state_out.passes_left < tsc_pkg::PASSES_NONE) begin
            state_out.passes_left = tsc_pkg::PASSES_ENDLESS;
         end
      end
   end

endmodule

[design/turn_signal_controller.sv]
// ----------------------------------------------------------------------------
// Turn signal controller
// Polls two turn buttons and drives the left and right three-lamp groups with
// comfort, long-hold and cancel behavior.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    left and right button levels
//  rsp       out        rsp_valid/rsp_ready    lamp groups and blink mode
//  csr       in         csr_write_enable       index and write data
//
// A poll is captured in the input register on acceptance and updated by the
// logic between the input register and the result register when it advances;
// its result then leaves the result register.
// One transaction is accepted per cycle while the result side keeps up.
// A stalled result register holds its transaction, and the input register
// fills behind it before req_ready drops.
// Synchronous reset restores the register defaults and the stopped state.
// ----------------------------------------------------------------------------
`include "turn_signal_controller_assert.svh"

module turn_signal_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_left_button,
   input  logic       req_right_button,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_left_lamps,
   output logic [2:0] rsp_right_lamps,
   output logic [1:0] rsp_blink_mode,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_write_data
);

   logic [7:0]         blink_step_polls_ff;
   logic [9:0]         long_press_polls_ff;
   logic [3:0]         comfort_cycles_ff;

   logic               in_valid_ff;
   logic               in_left_ff;
   logic               in_right_ff;

   logic               out_valid_ff;
   logic [2:0]         out_left_ff;
   logic [2:0]         out_right_ff;
   logic [1:0]         out_mode_ff;

   tsc_pkg::state_type state_ff;
   tsc_pkg::state_type event_state;
   tsc_pkg::state_type state_in;

   logic               advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_left_lamps = out_left_ff;
   assign rsp_right_lamps = out_right_ff;
   assign rsp_blink_mode = out_mode_ff;

   tsc_event_unit u_event (
      .state_in         (state_ff),
      .left_button      (in_left_ff),
      .right_button     (in_right_ff),
      .long_press_polls (long_press_polls_ff),
      .comfort_cycles   (comfort_cycles_ff),
      .state_out        (event_state)
   );

   tsc_blink_unit u_blink (
      .state_in         (event_state),
      .blink_step_polls (blink_step_polls_ff),
      .state_out        (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_step_polls_ff <= tsc_pkg::BLINK_STEP_RESET;
         long_press_polls_ff <= tsc_pkg::LONG_PRESS_RESET;
         comfort_cycles_ff <= tsc_pkg::COMFORT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tsc_pkg::CSR_BLINK_STEP_POLLS: begin
               blink_step_polls_ff <= csr_write_data[7:0];
            end
            tsc_pkg::CSR_LONG_PRESS_POLLS: begin
               long_press_polls_ff <= csr_write_data;
            end
            tsc_pkg::CSR_COMFORT_CYCLES: begin
               comfort_cycles_ff <= csr_write_data[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_left_ff <= req_left_button;
         in_right_ff <= req_right_button;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_left_ff <= state_in.left_out;
         out_right_ff <= state_in.right_out;
         out_mode_ff <= tsc_pkg::mode_code(state_in.mode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= tsc_pkg::MODE_STOP;
         state_ff.pattern_index <= '0;
         state_ff.passes_left <= tsc_pkg::PASSES_ENDLESS;
         state_ff.press_class <= tsc_pkg::CLS_NONE;
         state_ff.left_held <= 1'b0;
         state_ff.right_held <= 1'b0;
         state_ff.press_timer <= 10'd0;
         state_ff.press_timer_running <= 1'b0;
         state_ff.blink_timer <= 8'd0;
         state_ff.left_out <= tsc_pkg::LAMP_OFF;
         state_ff.right_out <= tsc_pkg::LAMP_OFF;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   `TSC_ASSERT_NEXT(a_result_holds, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff && $stable(out_left_ff) && $stable(out_right_ff) && $stable(out_mode_ff))
   `TSC_ASSERT_SAME(a_timer_needs_hold, clock, reset, state_ff.press_timer_running, state_ff.left_held || state_ff.right_held)
   `TSC_ASSERT_NEXT(a_state_moves_on_advance, clock, reset, !advance, $stable(state_ff))
   `TSC_ASSERT_NEXT(a_advance_fills_result, clock, reset, advance, out_valid_ff)

endmodule

[tb/sv/turn_signal_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turn signal controller testbench
// Drives button polls through the request channel and checks every lamp and
// blink mode transaction against a cycle-free model of the press detection,
// comfort blink, long hold and cancel behavior. A short directed sequence
// covers zero settings and cancels. Random button gestures then run under
// several register settings and idling patterns, with one long result stall.
// ----------------------------------------------------------------------------
module turn_signal_controller_test;

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic left_button;
      logic right_button;
   } button_poll_type;

   typedef struct packed {
      logic [2:0] left_lamps;
      logic [2:0] right_lamps;
      logic [1:0] blink_mode;
   } lamp_state_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_left_button = 1'b0;
   logic       req_right_button = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_left_lamps;
   logic [2:0] rsp_right_lamps;
   logic [1:0] rsp_blink_mode;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [9:0] csr_write_data = 10'd0;

   button_poll_type pending_polls[$];
   lamp_state_type  expected_lamps[$];
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   logic            result_holdoff = 1'b0;
   int              mismatch_count = 0;

   logic [7:0]               blink_step_cfg = tsc_pkg::BLINK_STEP_RESET;
   logic [9:0]               long_press_cfg = tsc_pkg::LONG_PRESS_RESET;
   logic [3:0]               comfort_cfg = tsc_pkg::COMFORT_RESET;
   tsc_pkg::mode_type        cur_mode = tsc_pkg::MODE_STOP;
   tsc_pkg::press_class_type gesture_class = tsc_pkg::CLS_NONE;
   int                       step_pos = 0;
   int                       passes_remaining = -1;
   logic                     left_down = 1'b0;
   logic                     right_down = 1'b0;
   int                       hold_count = 0;
   logic                     hold_counting = 1'b0;
   int                       step_count = 0;
   logic [2:0]               left_lamp = tsc_pkg::LAMP_OFF;
   logic [2:0]               right_lamp = tsc_pkg::LAMP_OFF;

   turn_signal_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_button  (req_left_button),
      .req_right_button (req_right_button),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_lamps   (rsp_left_lamps),
      .rsp_right_lamps  (rsp_right_lamps),
      .rsp_blink_mode   (rsp_blink_mode),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   task automatic predict_poll(input logic left_level, input logic right_level);
      tsc_pkg::button_event_type ev;
      lamp_state_type            lamps_now;
      logic [2:0]                lamp;
      ev = tsc_pkg::EV_NONE;
      if (hold_counting && hold_count < 1023) begin
         hold_count++;
      end
      if (left_level && !left_down) begin
         left_down = 1'b1;
         hold_count = 0;
         hold_counting = 1'b1;
         ev = tsc_pkg::EV_LPRESS;
      end else if (!left_level && left_down) begin
         left_down = 1'b0;
         hold_counting = 1'b0;
         ev = tsc_pkg::EV_LREL;
      end else if (left_down && hold_count >= long_press_cfg) begin
         ev = tsc_pkg::EV_LLONG;
      end else if (right_level && !right_down) begin
         right_down = 1'b1;
         hold_count = 0;
         hold_counting = 1'b1;
         ev = tsc_pkg::EV_RPRESS;
      end else if (!right_level && right_down) begin
         right_down = 1'b0;
         hold_counting = 1'b0;
         ev = tsc_pkg::EV_RREL;
      end else if (right_down && hold_count >= long_press_cfg) begin
         ev = tsc_pkg::EV_RLONG;
      end

      case (ev)
         tsc_pkg::EV_LPRESS: begin
            if (gesture_class == tsc_pkg::CLS_RSHORT) begin
               cur_mode = tsc_pkg::MODE_STOP;
               gesture_class = tsc_pkg::CLS_NONE;
            end else begin
               cur_mode = tsc_pkg::MODE_LEFT;
               passes_remaining = comfort_cfg;
               gesture_class = tsc_pkg::CLS_LSHORT;
            end
         end
         tsc_pkg::EV_LREL: begin
            if (gesture_class == tsc_pkg::CLS_LLONG) begin
               passes_remaining = 1;
            end
         end
         tsc_pkg::EV_LLONG: begin
            gesture_class = tsc_pkg::CLS_LLONG;
            cur_mode = tsc_pkg::MODE_LEFT;
            passes_remaining = -1;
         end
         tsc_pkg::EV_RPRESS: begin
            if (gesture_class == tsc_pkg::CLS_LSHORT) begin
               cur_mode = tsc_pkg::MODE_STOP;
               gesture_class = tsc_pkg::CLS_NONE;
            end else begin
               cur_mode = tsc_pkg::MODE_RIGHT;
               passes_remaining = comfort_cfg;
               gesture_class = tsc_pkg::CLS_RSHORT;
            end
         end
         tsc_pkg::EV_RREL: begin
            if (gesture_class == tsc_pkg::CLS_RLONG) begin
               passes_remaining = 1;
            end
         end
         tsc_pkg::EV_RLONG: begin
            gesture_class = tsc_pkg::CLS_RLONG;
            cur_mode = tsc_pkg::MODE_RIGHT;
            passes_remaining = -1;
         end
         default: begin
         end
      endcase
      if (cur_mode == tsc_pkg::MODE_STOP) begin
         gesture_class = tsc_pkg::CLS_NONE;
      end

      if (step_count < 255) begin
         step_count++;
      end
      if (step_count >= blink_step_cfg) begin
         step_count = 0;
         if (cur_mode == tsc_pkg::MODE_STOP) begin
            left_lamp = tsc_pkg::LAMP_OFF;
            right_lamp = tsc_pkg::LAMP_OFF;
            step_pos = 0;
         end else begin
            lamp = (step_pos < 3) ? (tsc_pkg::LAMP_RED << step_pos) : tsc_pkg::LAMP_OFF;
            if (cur_mode == tsc_pkg::MODE_LEFT) begin
               left_lamp = lamp;
               right_lamp = tsc_pkg::LAMP_OFF;
            end else begin
               left_lamp = tsc_pkg::LAMP_OFF;
               right_lamp = lamp;
            end
            step_pos++;
            if (step_pos >= tsc_pkg::PATTERN_LENGTH) begin
               step_pos = 0;
               passes_remaining--;
            end
         end
         if (passes_remaining == 0) begin
            cur_mode = tsc_pkg::MODE_STOP;
         end else if (passes_remaining < 0) begin
            passes_remaining = -1;
         end
      end

      lamps_now.left_lamps = left_lamp;
      lamps_now.right_lamps = right_lamp;
      case (cur_mode)
         tsc_pkg::MODE_LEFT: begin
            lamps_now.blink_mode = tsc_pkg::BLINK_MODE_LEFT;
         end
         tsc_pkg::MODE_RIGHT: begin
            lamps_now.blink_mode = tsc_pkg::BLINK_MODE_RIGHT;
         end
         default: begin
            lamps_now.blink_mode = tsc_pkg::BLINK_MODE_STOPPED;
         end
      endcase
      expected_lamps.push_back(lamps_now);
   endtask

   always @(posedge clock) begin : drive_polls
      button_poll_type next_poll;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_poll(req_left_button, req_right_button);
         end
         if (!req_valid || req_ready) begin
            if (pending_polls.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_poll = pending_polls.pop_front();
               req_valid <= 1'b1;
               req_left_button <= next_poll.left_button;
               req_right_button <= next_poll.right_button;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_lamps
      lamp_state_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !result_holdoff && ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_lamps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected transaction: left %0d right %0d mode %0d",
                           rsp_left_lamps, rsp_right_lamps, rsp_blink_mode);
               end
            end else begin
               want = expected_lamps.pop_front();
               if (rsp_left_lamps !== want.left_lamps ||
                   rsp_right_lamps !== want.right_lamps ||
                   rsp_blink_mode !== want.blink_mode) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"Lamp mismatch: expected left %0d right %0d mode %0d, ",
                               "got left %0d right %0d mode %0d"},
                              want.left_lamps, want.right_lamps, want.blink_mode,
                              rsp_left_lamps, rsp_right_lamps, rsp_blink_mode);
                  end
               end
            end
         end
      end
   end

   task automatic push_polls(input logic left_level, input logic right_level, input int count);
      button_poll_type poll;
      poll.left_button = left_level;
      poll.right_button = right_level;
      repeat (count) pending_polls.push_back(poll);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [9:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         tsc_pkg::CSR_BLINK_STEP_POLLS: begin
            blink_step_cfg = data[7:0];
         end
         tsc_pkg::CSR_LONG_PRESS_POLLS: begin
            long_press_cfg = data;
         end
         tsc_pkg::CSR_COMFORT_CYCLES: begin
            comfort_cfg = data[3:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_polls.size() != 0 || expected_lamps.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic start_phase(input int idle_pct, input int stall_pct, input logic [7:0] step_polls,
                              input logic [9:0] hold_polls, input logic [3:0] passes);
      wait_idle();
      write_register(tsc_pkg::CSR_BLINK_STEP_POLLS, 10'(step_polls));
      write_register(tsc_pkg::CSR_LONG_PRESS_POLLS, hold_polls);
      write_register(tsc_pkg::CSR_COMFORT_CYCLES, 10'(passes));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sender_idle_pct <= idle_pct;
      receiver_stall_pct <= stall_pct;
      @(negedge clock);
   endtask

   task automatic add_gestures(input int target, input int long_polls);
      int kind;
      int first_side;
      int span;
      while (pending_polls.size() < target) begin
         kind = $urandom_range(9);
         first_side = $urandom_range(1);
         span = $urandom_range(1) ? $urandom_range(1, long_polls + 1)
                                  : long_polls + $urandom_range(1, 12);
         if (kind <= 5) begin
            push_polls(first_side == 0, first_side == 1, span);
            push_polls(1'b0, 1'b0, $urandom_range(1) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 40));
         end else if (kind == 6) begin
            push_polls(first_side == 0, first_side == 1, $urandom_range(1, 4));
            push_polls(1'b1, 1'b1, span);
            push_polls(first_side == 1, first_side == 0, $urandom_range(1, 4));
            push_polls(1'b0, 1'b0, $urandom_range(1, 6));
         end else if (kind == 7) begin
            push_polls(1'b1, 1'b1, span);
            push_polls(1'b0, 1'b0, $urandom_range(1, 6));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               push_polls(1'($urandom_range(1)), 1'($urandom_range(1)), 1);
            end
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_register(CSR_UNUSED_INDEX, 10'h3FF);
      start_phase(0, 0, 8'd0, 10'd0, 4'd0);
      push_polls(1'b0, 1'b0, 1);
      push_polls(1'b1, 1'b0, 2);
      push_polls(1'b0, 1'b0, 1);
      push_polls(1'b0, 1'b1, 2);
      push_polls(1'b1, 1'b1, 2);
      push_polls(1'b0, 1'b1, 1);
      push_polls(1'b0, 1'b0, 1);

      start_phase(0, 0, 8'd2, 10'd4, 4'd2);
      push_polls(1'b1, 1'b0, 1);
      push_polls(1'b0, 1'b0, 1);
      push_polls(1'b0, 1'b1, 1);
      push_polls(1'b0, 1'b0, 2);
      push_polls(1'b0, 1'b1, 1);
      push_polls(1'b0, 1'b0, 1);
      push_polls(1'b1, 1'b0, 1);
      push_polls(1'b0, 1'b0, 3);

      start_phase(0, 0, 8'd1, 10'd3, 4'd1);
      add_gestures(100, 3);
      start_phase(55, 0, 8'd3, 10'd8, 4'd3);
      add_gestures(100, 8);
      start_phase(0, 55, 8'd5, 10'd12, 4'd15);
      add_gestures(100, 12);
      start_phase(21, 21, 8'd0, 10'd1, 4'd0);
      add_gestures(100, 1);

      start_phase(0, 0, 8'd2, 10'd6, 4'd2);
      add_gestures(80, 6);
      fork
         begin
            @(posedge clock);
            result_holdoff <= 1'b1;
            repeat (60) @(posedge clock);
            result_holdoff <= 1'b0;
         end
      join_none

      start_phase(21, 21, 8'd255, 10'd1023, 4'd15);
      push_polls(1'b1, 1'b0, 1030);
      push_polls(1'b0, 1'b0, 5);
      push_polls(1'b0, 1'b1, 3);
      push_polls(1'b0, 1'b0, 20);

      start_phase(21, 21, tsc_pkg::BLINK_STEP_RESET, tsc_pkg::LONG_PRESS_RESET,
                  tsc_pkg::COMFORT_RESET);
      add_gestures(180, 60);

      wait_idle();
      if (mismatch_count == 0 && expected_lamps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
